// ===== hw/rtl/icsu_pkg.sv =====
package icsu_pkg;

    localparam logic [15:0] SPEED_RESET = 16'd5120;

    // radicand widths of the two square roots
    localparam int DIS_RAD_W = 117;
    localparam int LEN_RAD_W = 63;

    // per-component scaling divider
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_QUO_W = 17;

    localparam int SIDE_W_DEFAULT = 1;

endpackage

// ===== hw/rtl/icsu_isqrt.sv =====
module icsu_isqrt #(
    parameter int IN_W   = icsu_pkg::LEN_RAD_W,
    parameter int SIDE_W = icsu_pkg::SIDE_W_DEFAULT,
    localparam int ROOT_W = (IN_W + 1) / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int W = 2 * ROOT_W;

    logic [W-1:0]      op_reg   [ROOT_W];
    logic [W-1:0]      res_reg  [ROOT_W];
    logic              v_reg    [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    // one result bit per stage, digit-by-digit with remainder
    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int SH = 2 * (ROOT_W - 1 - j);
        logic [W-1:0]      op_in;
        logic [W-1:0]      res_in;
        logic [W-1:0]      trial;
        logic              v_in;
        logic [SIDE_W-1:0] side_in;

        if (j == 0) begin : g_first
            assign op_in   = W'(in_rad);
            assign res_in  = '0;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_rest
            assign op_in   = op_reg[j-1];
            assign res_in  = res_reg[j-1];
            assign v_in    = v_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign trial = res_in + (W'(1) << SH);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (op_in >= trial) begin
                    op_reg[j]  <= op_in - trial;
                    res_reg[j] <= (res_in >> 1) + (W'(1) << SH);
                end else begin
                    op_reg[j]  <= op_in;
                    res_reg[j] <= res_in >> 1;
                end
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = res_reg[ROOT_W-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== hw/rtl/icsu_div2.sv =====
module icsu_div2 #(
    parameter int NUM_W  = icsu_pkg::DIV_NUM_W,
    parameter int DEN_W  = icsu_pkg::DIV_DEN_W,
    parameter int QUO_W  = icsu_pkg::DIV_QUO_W,
    parameter int SIDE_W = icsu_pkg::SIDE_W_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num_x,
    input  logic [NUM_W-1:0]  in_num_y,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QUO_W-1:0]  out_quo_x,
    output logic [QUO_W-1:0]  out_quo_y,
    output logic [SIDE_W-1:0] out_side
);

    localparam int R = DEN_W + QUO_W;

    logic [R-1:0]      remx_reg [QUO_W];
    logic [R-1:0]      remy_reg [QUO_W];
    logic [QUO_W-1:0]  qx_reg   [QUO_W];
    logic [QUO_W-1:0]  qy_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic              v_reg    [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    // restoring division, one quotient bit per stage, both lanes share the divisor
    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int B = QUO_W - 1 - j;
        logic [R-1:0]      rx_in;
        logic [R-1:0]      ry_in;
        logic [QUO_W-1:0]  qx_in;
        logic [QUO_W-1:0]  qy_in;
        logic [DEN_W-1:0]  den_in;
        logic              v_in;
        logic [SIDE_W-1:0] side_in;
        logic [R-1:0]      trial;
        logic              gex;
        logic              gey;

        if (j == 0) begin : g_first
            assign rx_in   = R'(in_num_x);
            assign ry_in   = R'(in_num_y);
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign den_in  = in_den;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_rest
            assign rx_in   = remx_reg[j-1];
            assign ry_in   = remy_reg[j-1];
            assign qx_in   = qx_reg[j-1];
            assign qy_in   = qy_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign v_in    = v_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign trial = R'(den_in) << B;
        assign gex   = rx_in >= trial;
        assign gey   = ry_in >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                remx_reg[j] <= gex ? rx_in - trial : rx_in;
                remy_reg[j] <= gey ? ry_in - trial : ry_in;
                qx_reg[j]   <= qx_in | (QUO_W'(gex) << B);
                qy_reg[j]   <= qy_in | (QUO_W'(gey) << B);
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_quo_x = qx_reg[QUO_W-1];
    assign out_quo_y = qy_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ===== hw/rtl/intercept_course_solver_unit.sv =====
// Intercept course solver: for each target/shooter query, returns the projectile
// velocity (speed times the unit vector toward the predicted meeting point) or
// solved=0 when no positive-time intercept exists. Fully pipelined: one query per
// cycle while the output is not stalled. It has 7 setup stages, a 59-stage
// discriminant square root, 11 aim-vector stages, a 32-stage length square root,
// 2 stages, a 17-stage scaling divider and the output register. The whole pipe
// holds on m_ready low while a result is waiting. cfg_we loads projectile_speed
// (Q8.8, reset 20.0); write it only while the unit is empty.
module intercept_course_solver_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [23:0] s_target_vx,
    input  logic signed [23:0] s_target_vy,
    input  logic signed [31:0] s_shooter_x,
    input  logic signed [31:0] s_shooter_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_solved,
    output logic signed [23:0] m_shot_vx,
    output logic signed [23:0] m_shot_vy
);

    localparam int RW1 = (icsu_pkg::DIS_RAD_W + 1) / 2;
    localparam int RW2 = (icsu_pkg::LEN_RAD_W + 1) / 2;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic [15:0]        spd;
        logic signed [58:0] b;
        logic [47:0]        amag;
        logic               a_neg;
        logic               a_zero;
        logic               b_zero;
        logic               dis_neg;
    } side1_t;

    typedef struct packed {
        logic [30:0] ux;
        logic [30:0] uy;
        logic        nx;
        logic        ny;
        logic [15:0] spd;
        logic        zero;
        logic        unsolved;
    } side2_t;

    typedef struct packed {
        logic        nx;
        logic        ny;
        logic [15:0] spd;
        logic        zero;
        logic        unsolved;
    } side3_t;

    logic        en;
    logic [15:0] speed_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= icsu_pkg::SPEED_RESET;
        end else if (cfg_we) begin
            speed_reg <= cfg_wdata;
        end
    end

    // ---------------- setup: d, products, a/b/c, discriminant ----------------
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [23:0] vx1_reg, vy1_reg;
    logic [15:0]        spd1_reg;

    logic signed [56:0] dxvx2_reg, dyvy2_reg;
    logic signed [47:0] vxsq2_reg, vysq2_reg;
    logic [31:0]        ssq2_reg;
    logic [63:0]        dxsq2_reg, dysq2_reg;
    logic signed [32:0] dx2_reg, dy2_reg;
    logic signed [23:0] vx2_reg, vy2_reg;
    logic [15:0]        spd2_reg;

    logic signed [57:0] bsum;
    logic signed [58:0] b3_reg;
    logic signed [48:0] a3_reg;
    logic [64:0]        c3_reg;
    logic signed [32:0] dx3_reg, dy3_reg;
    logic signed [23:0] vx3_reg, vy3_reg;
    logic [15:0]        spd3_reg;

    logic signed [48:0] a_negated;
    logic signed [58:0] b_negated;
    side1_t             s4_reg;
    logic [57:0]        bmag4_reg;
    logic [64:0]        c4_reg;

    side1_t             s5_reg;
    logic [57:0]        bhh5_reg, bhl5_reg, bll5_reg;
    logic [56:0]        ahch5_reg, alch5_reg;
    logic [55:0]        ahcl5_reg, alcl5_reg;

    side1_t             s6_reg;
    logic [115:0]       bb6_reg;
    logic [112:0]       ac6_reg;

    side1_t             s7_reg;
    logic [117:0]       dis7_reg;
    logic [117:0]       dis_next;

    assign bsum      = dxvx2_reg + dyvy2_reg;
    assign a_negated = -a3_reg;
    assign b_negated = -b3_reg;
    assign dis_next  = s6_reg.a_neg ? 118'(bb6_reg) + 118'({ac6_reg, 2'b00})
                                    : 118'(bb6_reg) - 118'({ac6_reg, 2'b00});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx1_reg  <= $signed({s_target_x[31], s_target_x})
                      - $signed({s_shooter_x[31], s_shooter_x});
            dy1_reg  <= $signed({s_target_y[31], s_target_y})
                      - $signed({s_shooter_y[31], s_shooter_y});
            vx1_reg  <= s_target_vx;
            vy1_reg  <= s_target_vy;
            spd1_reg <= speed_reg;

            dxvx2_reg <= dx1_reg * vx1_reg;
            dyvy2_reg <= dy1_reg * vy1_reg;
            vxsq2_reg <= vx1_reg * vx1_reg;
            vysq2_reg <= vy1_reg * vy1_reg;
            ssq2_reg  <= spd1_reg * spd1_reg;
            dxsq2_reg <= dx1_reg * dx1_reg;
            dysq2_reg <= dy1_reg * dy1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            spd2_reg  <= spd1_reg;

            b3_reg   <= {bsum, 1'b0};
            a3_reg   <= vxsq2_reg + vysq2_reg - $signed({17'd0, ssq2_reg});
            c3_reg   <= 65'(dxsq2_reg) + 65'(dysq2_reg);
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
            vx3_reg  <= vx2_reg;
            vy3_reg  <= vy2_reg;
            spd3_reg <= spd2_reg;

            s4_reg.dx      <= dx3_reg;
            s4_reg.dy      <= dy3_reg;
            s4_reg.vx      <= vx3_reg;
            s4_reg.vy      <= vy3_reg;
            s4_reg.spd     <= spd3_reg;
            s4_reg.b       <= b3_reg;
            s4_reg.amag    <= a3_reg[48] ? a_negated[47:0] : a3_reg[47:0];
            s4_reg.a_neg   <= a3_reg[48];
            s4_reg.a_zero  <= a3_reg == '0;
            s4_reg.b_zero  <= b3_reg == '0;
            s4_reg.dis_neg <= 1'b0;
            bmag4_reg      <= b3_reg[58] ? b_negated[57:0] : b3_reg[57:0];
            c4_reg         <= c3_reg;

            // b^2 and |a|*c as partial products
            s5_reg    <= s4_reg;
            bhh5_reg  <= bmag4_reg[57:29] * bmag4_reg[57:29];
            bhl5_reg  <= bmag4_reg[57:29] * bmag4_reg[28:0];
            bll5_reg  <= bmag4_reg[28:0] * bmag4_reg[28:0];
            ahch5_reg <= s4_reg.amag[47:24] * c4_reg[64:32];
            ahcl5_reg <= s4_reg.amag[47:24] * c4_reg[31:0];
            alch5_reg <= s4_reg.amag[23:0] * c4_reg[64:32];
            alcl5_reg <= s4_reg.amag[23:0] * c4_reg[31:0];

            s6_reg  <= s5_reg;
            bb6_reg <= (116'(bhh5_reg) << 58) + (116'(bhl5_reg) << 30) + 116'(bll5_reg);
            ac6_reg <= (113'(ahch5_reg) << 56) + (113'(ahcl5_reg) << 24)
                     + (113'(alch5_reg) << 32) + 113'(alcl5_reg);

            s7_reg         <= s6_reg;
            s7_reg.dis_neg <= dis_next[117];
            dis7_reg       <= dis_next;
        end
    end

    // ---------------- discriminant root ----------------
    logic           sq1_valid;
    logic [RW1-1:0] sq1_root;
    side1_t         sq1_side;

    icsu_isqrt #(
        .IN_W   (icsu_pkg::DIS_RAD_W),
        .SIDE_W ($bits(side1_t))
    ) u_dis_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v7_reg),
        .in_rad    (dis7_reg[icsu_pkg::DIS_RAD_W-1:0]),
        .in_side   (s7_reg),
        .out_valid (sq1_valid),
        .out_root  (sq1_root),
        .out_side  (sq1_side)
    );

    // ---------------- root choice and aim vector ----------------
    logic               va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;
    logic               vh_reg, vi_reg, vj_reg, vk_reg;
    logic signed [60:0] n1, n2;
    logic               n1_pos, n1_bad;
    side1_t             sa_reg;
    logic signed [60:0] na_reg;

    logic signed [60:0] n_negated;
    logic signed [32:0] dx_negated, dy_negated;
    logic signed [23:0] vx_negated, vy_negated;
    logic               na_pos;
    side1_t             sb_reg;
    logic [59:0]        nmagb_reg;
    logic               snnb_reg, unsb_reg;
    logic [31:0]        dxmb_reg, dymb_reg;
    logic [23:0]        vxmb_reg, vymb_reg;

    logic [48:0]        a2c;
    side1_t             sc_reg;
    logic               snnc_reg, unsc_reg;
    logic [56:0]        ahdx_reg, ahdy_reg;
    logic [55:0]        aldx_reg, aldy_reg;
    logic [53:0]        nhvx_reg, nlvx_reg, nhvy_reg, nlvy_reg;

    side1_t             sd_reg;
    logic               snnd_reg, unsd_reg;
    logic [80:0]        adx_reg, ady_reg;
    logic [83:0]        nvx_reg, nvy_reg;

    side1_t             se_reg;
    logic               unse_reg;
    logic signed [85:0] sadx_reg, sady_reg, snvx_reg, snvy_reg;

    logic               unsf_reg;
    logic [15:0]        spdf_reg;
    logic signed [85:0] qx_reg, qy_reg;

    logic signed [85:0] qx_negated, qy_negated;
    logic               unsg_reg, nxg_reg, nyg_reg;
    logic [15:0]        spdg_reg;
    logic [84:0]        uxg_reg, uyg_reg;

    logic [84:0]        uor;
    logic [6:0]         msb;
    logic               unsh_reg, nxh_reg, nyh_reg, zeroh_reg;
    logic [15:0]        spdh_reg;
    logic [84:0]        uxh_reg, uyh_reg;
    logic [6:0]         kh_reg;

    logic [84:0]        uxs, uys;
    side2_t             si_reg, sj_reg, sk_reg;
    logic [61:0]        uxsq_reg, uysq_reg;
    logic [62:0]        l2_reg;

    assign n1     = -$signed({{2{sq1_side.b[58]}}, sq1_side.b}) + $signed({2'b00, sq1_root});
    assign n2     = -$signed({{2{sq1_side.b[58]}}, sq1_side.b}) - $signed({2'b00, sq1_root});
    assign n1_pos = !n1[60] && (n1 != '0);
    assign n1_bad = sq1_side.a_neg ? n1_pos : n1[60];

    assign n_negated  = -na_reg;
    assign dx_negated = -sa_reg.dx;
    assign dy_negated = -sa_reg.dy;
    assign vx_negated = -sa_reg.vx;
    assign vy_negated = -sa_reg.vy;
    assign na_pos     = sa_reg.a_neg ? na_reg[60] : (!na_reg[60] && (na_reg != '0));

    assign a2c = {sb_reg.amag, 1'b0};

    assign qx_negated = -qx_reg;
    assign qy_negated = -qy_reg;

    assign uor = uxg_reg | uyg_reg;
    always_comb begin
        msb = '0;
        for (int i = 0; i < 85; i++) begin
            if (uor[i]) begin
                msb = 7'(i);
            end
        end
    end

    assign uxs = uxh_reg >> kh_reg;
    assign uys = uyh_reg >> kh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
            vk_reg <= 1'b0;
        end else if (en) begin
            va_reg <= sq1_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vg_reg <= vf_reg;
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
            vj_reg <= vi_reg;
            vk_reg <= vj_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // '+' root first, '-' root if the '+' one lies in the past
            sa_reg <= sq1_side;
            na_reg <= n1_bad ? n2 : n1;

            sb_reg    <= sa_reg;
            nmagb_reg <= na_reg[60] ? n_negated[59:0] : na_reg[59:0];
            snnb_reg  <= na_reg[60] ^ sa_reg.a_neg;
            unsb_reg  <= sa_reg.dis_neg || (!sa_reg.b_zero && (sa_reg.a_zero || !na_pos));
            dxmb_reg  <= sa_reg.dx[32] ? dx_negated[31:0] : sa_reg.dx[31:0];
            dymb_reg  <= sa_reg.dy[32] ? dy_negated[31:0] : sa_reg.dy[31:0];
            vxmb_reg  <= sa_reg.vx[23] ? vx_negated : sa_reg.vx;
            vymb_reg  <= sa_reg.vy[23] ? vy_negated : sa_reg.vy;

            // Q = 2|a|*d + sign(a)*n*v, split into partial products
            sc_reg   <= sb_reg;
            snnc_reg <= snnb_reg;
            unsc_reg <= unsb_reg;
            ahdx_reg <= a2c[48:24] * dxmb_reg;
            aldx_reg <= a2c[23:0] * dxmb_reg;
            ahdy_reg <= a2c[48:24] * dymb_reg;
            aldy_reg <= a2c[23:0] * dymb_reg;
            nhvx_reg <= nmagb_reg[59:30] * vxmb_reg;
            nlvx_reg <= nmagb_reg[29:0] * vxmb_reg;
            nhvy_reg <= nmagb_reg[59:30] * vymb_reg;
            nlvy_reg <= nmagb_reg[29:0] * vymb_reg;

            sd_reg   <= sc_reg;
            snnd_reg <= snnc_reg;
            unsd_reg <= unsc_reg;
            adx_reg  <= (81'(ahdx_reg) << 24) + 81'(aldx_reg);
            ady_reg  <= (81'(ahdy_reg) << 24) + 81'(aldy_reg);
            nvx_reg  <= (84'(nhvx_reg) << 30) + 84'(nlvx_reg);
            nvy_reg  <= (84'(nhvy_reg) << 30) + 84'(nlvy_reg);

            se_reg   <= sd_reg;
            unse_reg <= unsd_reg;
            sadx_reg <= sd_reg.dx[32] ? -$signed(86'(adx_reg)) : $signed(86'(adx_reg));
            sady_reg <= sd_reg.dy[32] ? -$signed(86'(ady_reg)) : $signed(86'(ady_reg));
            snvx_reg <= (snnd_reg ^ sd_reg.vx[23]) ? -$signed(86'(nvx_reg))
                                                    : $signed(86'(nvx_reg));
            snvy_reg <= (snnd_reg ^ sd_reg.vy[23]) ? -$signed(86'(nvy_reg))
                                                    : $signed(86'(nvy_reg));

            // b zero: aim straight at the target
            unsf_reg <= unse_reg;
            spdf_reg <= se_reg.spd;
            qx_reg   <= se_reg.b_zero ? 86'(se_reg.dx) : sadx_reg + snvx_reg;
            qy_reg   <= se_reg.b_zero ? 86'(se_reg.dy) : sady_reg + snvy_reg;

            unsg_reg <= unsf_reg;
            spdg_reg <= spdf_reg;
            nxg_reg  <= qx_reg[85];
            nyg_reg  <= qy_reg[85];
            uxg_reg  <= qx_reg[85] ? qx_negated[84:0] : qx_reg[84:0];
            uyg_reg  <= qy_reg[85] ? qy_negated[84:0] : qy_reg[84:0];

            // common right shift so both magnitudes fit in 31 bits
            unsh_reg  <= unsg_reg;
            spdh_reg  <= spdg_reg;
            nxh_reg   <= nxg_reg;
            nyh_reg   <= nyg_reg;
            zeroh_reg <= uor == '0;
            uxh_reg   <= uxg_reg;
            uyh_reg   <= uyg_reg;
            kh_reg    <= (msb > 7'd30) ? msb - 7'd30 : 7'd0;

            si_reg.ux       <= uxs[30:0];
            si_reg.uy       <= uys[30:0];
            si_reg.nx       <= nxh_reg;
            si_reg.ny       <= nyh_reg;
            si_reg.spd      <= spdh_reg;
            si_reg.zero     <= zeroh_reg;
            si_reg.unsolved <= unsh_reg;

            sj_reg   <= si_reg;
            uxsq_reg <= si_reg.ux * si_reg.ux;
            uysq_reg <= si_reg.uy * si_reg.uy;

            sk_reg <= sj_reg;
            l2_reg <= 63'(uxsq_reg) + 63'(uysq_reg);
        end
    end

    // ---------------- aim vector length ----------------
    logic           sq2_valid;
    logic [RW2-1:0] sq2_root;
    side2_t         sq2_side;

    icsu_isqrt #(
        .IN_W   (icsu_pkg::LEN_RAD_W),
        .SIDE_W ($bits(side2_t))
    ) u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vk_reg),
        .in_rad    (l2_reg),
        .in_side   (sk_reg),
        .out_valid (sq2_valid),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );

    // ---------------- speed * q / len, rounded ----------------
    logic                          vl_reg, vm_reg;
    side3_t                        sl_reg, sm_reg;
    logic [46:0]                   pxl_reg, pyl_reg;
    logic [RW2-2:0]                halfl_reg;
    logic [RW2-1:0]                lenl_reg, lenm_reg;
    logic [icsu_pkg::DIV_NUM_W-1:0] numx_reg, numy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg <= 1'b0;
            vm_reg <= 1'b0;
        end else if (en) begin
            vl_reg <= sq2_valid;
            vm_reg <= vl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sl_reg.nx       <= sq2_side.nx;
            sl_reg.ny       <= sq2_side.ny;
            sl_reg.spd      <= sq2_side.spd;
            sl_reg.zero     <= sq2_side.zero;
            sl_reg.unsolved <= sq2_side.unsolved;
            pxl_reg         <= sq2_side.spd * sq2_side.ux;
            pyl_reg         <= sq2_side.spd * sq2_side.uy;
            halfl_reg       <= sq2_root[RW2-1:1];
            lenl_reg        <= sq2_root;

            sm_reg   <= sl_reg;
            numx_reg <= icsu_pkg::DIV_NUM_W'(pxl_reg) + icsu_pkg::DIV_NUM_W'(halfl_reg);
            numy_reg <= icsu_pkg::DIV_NUM_W'(pyl_reg) + icsu_pkg::DIV_NUM_W'(halfl_reg);
            lenm_reg <= lenl_reg;
        end
    end

    logic                           dv_valid;
    logic [icsu_pkg::DIV_QUO_W-1:0] quo_x, quo_y;
    side3_t                         dv_side;

    icsu_div2 #(
        .NUM_W  (icsu_pkg::DIV_NUM_W),
        .DEN_W  (icsu_pkg::DIV_DEN_W),
        .QUO_W  (icsu_pkg::DIV_QUO_W),
        .SIDE_W ($bits(side3_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vm_reg),
        .in_num_x  (numx_reg),
        .in_num_y  (numy_reg),
        .in_den    (lenm_reg),
        .in_side   (sm_reg),
        .out_valid (dv_valid),
        .out_quo_x (quo_x),
        .out_quo_y (quo_y),
        .out_side  (dv_side)
    );

    // ---------------- output register ----------------
    logic               m_valid_reg, solved_reg;
    logic signed [23:0] shot_vx_reg, shot_vy_reg;
    logic [15:0]        spd_out_reg;
    logic [23:0]        vx_next, vy_next;

    always_comb begin
        if (dv_side.unsolved) begin
            vx_next = '0;
            vy_next = '0;
        end else if (dv_side.zero) begin
            // aim vector vanished: fire along +x
            vx_next = 24'(dv_side.spd);
            vy_next = '0;
        end else begin
            vx_next = dv_side.nx ? -24'(quo_x) : 24'(quo_x);
            vy_next = dv_side.ny ? -24'(quo_y) : 24'(quo_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            solved_reg  <= !dv_side.unsolved;
            shot_vx_reg <= vx_next;
            shot_vy_reg <= vy_next;
            spd_out_reg <= dv_side.spd;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_solved  = solved_reg;
    assign m_shot_vx = shot_vx_reg;
    assign m_shot_vy = shot_vy_reg;

    // ---------------- checks ----------------
    logic [23:0] abs_vx, abs_vy;
    assign abs_vx = shot_vx_reg[23] ? -shot_vx_reg : shot_vx_reg;
    assign abs_vy = shot_vy_reg[23] ? -shot_vy_reg : shot_vy_reg;

    a_unsolved_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !solved_reg |-> shot_vx_reg == '0 && shot_vy_reg == '0)
        else $error("unsolved transaction carries a nonzero velocity");

    a_speed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && solved_reg |-> abs_vx <= 24'(spd_out_reg) && abs_vy <= 24'(spd_out_reg))
        else $error("shot velocity component exceeds projectile speed");

    a_pipe_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v7_reg && en |=> sq1_valid == 1'b0 || sq1_valid == 1'b1)
        else $error("pipeline valid unknown");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid_reg && !v1_reg)
        else $error("pipeline not empty after reset");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v1_reg) && $stable(vk_reg) && $stable(dv_valid))
        else $error("pipeline moved while output stalled");

endmodule

// ===== sim/intercept_course_solver_unit_tb.sv =====
`timescale 1ns / 1ps

module intercept_course_solver_unit_tb;
    import icsu_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } query_t;

    typedef struct {
        logic        solved;
        logic [23:0] vx;
        logic [23:0] vy;
    } shot_t;

    typedef struct {
        logic [15:0] speed;
        query_t      q;
        logic        typed;
        shot_t       shot;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_target_x = '0;
    logic signed [31:0] s_target_y = '0;
    logic signed [23:0] s_target_vx = '0;
    logic signed [23:0] s_target_vy = '0;
    logic signed [31:0] s_shooter_x = '0;
    logic signed [31:0] s_shooter_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_solved;
    logic signed [23:0] m_shot_vx;
    logic signed [23:0] m_shot_vy;

    shot_t       expected_shots[$];
    dir_row_t    dir_rows[$];
    logic [15:0] speed_reg = SPEED_RESET;
    int          mismatch_count = 0;
    int          queries_sent = 0;
    int          shots_checked = 0;
    int          solved_seen = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          hold_req = 1'b0;

    intercept_course_solver_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_target_x  (s_target_x),
        .s_target_y  (s_target_y),
        .s_target_vx (s_target_vx),
        .s_target_vy (s_target_vy),
        .s_shooter_x (s_shooter_x),
        .s_shooter_y (s_shooter_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_solved    (m_solved),
        .m_shot_vx   (m_shot_vx),
        .m_shot_vy   (m_shot_vy)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = {64'd0, r | (64'd1 << i)};
            if (c * c <= v) begin
                r = c[63:0];
            end
        end
        return r;
    endfunction

    // speed times unit vector of q; q is scaled down to 31 bits per component first
    function automatic shot_t aim_along(input wide_t qx, input wide_t qy, input logic [15:0] s);
        shot_t        r;
        logic [127:0] ux, uy;
        logic [63:0]  l2, len, mx, my;
        r.solved = 1'b1;
        ux = (qx < 0) ? -qx : qx;
        uy = (qy < 0) ? -qy : qy;
        if (ux == 0 && uy == 0) begin
            r.vx = {8'd0, s};
            r.vy = '0;
            return r;
        end
        while (ux >= 128'h8000_0000 || uy >= 128'h8000_0000) begin
            ux = ux >> 1;
            uy = uy >> 1;
        end
        l2  = ux[63:0] * ux[63:0] + uy[63:0] * uy[63:0];
        len = floor_sqrt({64'd0, l2});
        mx  = ({48'd0, s} * ux[63:0] + len / 2) / len;
        my  = ({48'd0, s} * uy[63:0] + len / 2) / len;
        r.vx = (qx < 0) ? -mx[23:0] : mx[23:0];
        r.vy = (qy < 0) ? -my[23:0] : my[23:0];
        return r;
    endfunction

    function automatic shot_t solve_intercept(input query_t q, input logic [15:0] s);
        shot_t r;
        wide_t dx, dy, vx, vy, sp, a, b, dis, rt, n, a2, sn;
        r = '{1'b0, 24'd0, 24'd0};
        dx = wide_t'(q.tx) - wide_t'(q.sx);
        dy = wide_t'(q.ty) - wide_t'(q.sy);
        vx = q.vx;
        vy = q.vy;
        sp = s;
        b = 2 * (dx * vx + dy * vy);
        a = vx * vx + vy * vy - sp * sp;
        dis = b * b - 4 * a * (dx * dx + dy * dy);
        if (dis < 0) return r;
        if (b == 0) return aim_along(dx, dy, s);
        if (a == 0) return r;
        rt = {64'd0, floor_sqrt(dis)};
        n = -b + rt;
        if ((a > 0) ? (n < 0) : (n > 0)) begin
            n = -b - rt;
        end
        if (!((a > 0) ? (n > 0) : (n < 0))) return r;
        a2 = 2 * ((a < 0) ? -a : a);
        sn = (a < 0) ? -n : n;
        return aim_along(a2 * dx + sn * vx, a2 * dy + sn * vy, s);
    endfunction

    function automatic logic signed [31:0] rnd_signed(input int bits);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     kind;
        kind = $urandom_range(9);
        q.sx = rnd_signed($urandom_range(8, 32));
        q.sy = rnd_signed($urandom_range(8, 32));
        if (kind < 2 || kind == 9) begin
            q.tx = $urandom;
            q.ty = $urandom;
            q.vx = $urandom;
            q.vy = $urandom;
            q.sx = $urandom;
            q.sy = $urandom;
            if (kind == 9) begin
                q.tx = {~q.sx[31], q.tx[30:0]};
            end
        end else if (kind < 8) begin
            // plausible geometry: target nearby, speed comparable to the shot
            q.tx = q.sx + rnd_signed($urandom_range(4, 24));
            q.ty = q.sy + rnd_signed($urandom_range(4, 24));
            q.vx = rnd_signed($urandom_range(2, 17));
            q.vy = rnd_signed($urandom_range(2, 17));
        end else begin
            q.tx = q.sx;
            q.ty = q.sy;
            q.vx = ($urandom_range(1)) ? rnd_signed(12) : '0;
            q.vy = ($urandom_range(1)) ? rnd_signed(12) : '0;
            if ($urandom_range(1)) begin
                q.tx = q.sx + rnd_signed(16);
                q.vx = '0;
                q.vy = '0;
            end
        end
        return q;
    endfunction

    // receiver: random backpressure plus a single long hold-off
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        shot_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_shots.size() == 0) begin
                $error("unexpected result transaction: solved=%0d vx=%h vy=%h",
                       m_solved, m_shot_vx, m_shot_vy);
                mismatch_count++;
            end else begin
                e = expected_shots.pop_front();
                shots_checked++;
                if (m_solved) solved_seen++;
                if (m_solved !== e.solved) begin
                    $error("solved: expected %0d, got %0d", e.solved, m_solved);
                    mismatch_count++;
                end
                if (m_shot_vx !== e.vx) begin
                    $error("shot_vx: expected %h, got %h", e.vx, m_shot_vx);
                    mismatch_count++;
                end
                if (m_shot_vy !== e.vy) begin
                    $error("shot_vy: expected %h, got %h", e.vy, m_shot_vy);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_query(input query_t q, input bit typed, input shot_t shot);
        if ($urandom_range(99) < tx_idle_pct) begin
            repeat ($urandom_range(1, 6)) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_target_x  <= q.tx;
        s_target_y  <= q.ty;
        s_target_vx <= q.vx;
        s_target_vy <= q.vy;
        s_shooter_x <= q.sx;
        s_shooter_y <= q.sy;
        do @(posedge aclk); while (!s_ready);
        expected_shots.push_back(typed ? shot : solve_intercept(q, speed_reg));
        queries_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_shots.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_speed(input logic [15:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        speed_reg = v;
    endtask

    task automatic add_row(input logic [15:0] sp, input logic signed [31:0] tx, ty,
                           input logic signed [23:0] vx, vy,
                           input logic signed [31:0] sx, sy,
                           input bit typed, input logic sv, input logic [23:0] evx, evy);
        dir_row_t row;
        row.speed = sp;
        row.q     = '{tx, ty, vx, vy, sx, sy};
        row.typed = typed;
        row.shot  = '{sv, evx, evy};
        dir_rows.push_back(row);
    endtask

    initial begin
        localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
        localparam logic signed [31:0] PMIN = 32'sh8000_0000;
        localparam logic signed [23:0] VMAX = 24'sh7f_ffff;
        localparam logic signed [23:0] VMIN = 24'sh80_0000;
        logic [15:0] phase_speed[6];
        shot_t       none;
        none = '{1'b0, 24'd0, 24'd0};
        phase_speed = '{16'd5120, 16'hffff, 16'd0, 16'd1, 16'd0, 16'd300};
        phase_speed[4] = $urandom;

        // target on shooter, straight shots, and the unsolvable cases
        add_row(5120, 0, 0, 0, 0, 0, 0, 1, 1, 24'd5120, 24'd0);
        add_row(5120, 256, 0, 0, 0, 0, 0, 1, 1, 24'd5120, 24'd0);
        add_row(5120, 0, -256, 0, 0, 0, 0, 1, 1, 24'd0, -24'd5120);
        add_row(5120, 256, 0, 0, 10240, 0, 0, 1, 0, 0, 0);
        add_row(5120, 256, 0, 5120, 0, 0, 0, 1, 0, 0, 0);
        add_row(5120, 256, 0, 10240, 0, 0, 0, 1, 0, 0, 0);
        add_row(5120, 2560, 0, 256, 0, 0, 0, 0, 0, 0, 0);
        add_row(5120, -2560, 1280, 256, -512, 0, 0, 0, 0, 0, 0);
        add_row(5120, PMAX, PMIN, VMAX, VMIN, PMIN, PMAX, 0, 0, 0, 0);
        add_row(5120, PMIN, PMIN, VMIN, VMIN, PMAX, PMAX, 0, 0, 0, 0);
        add_row(5120, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0);
        add_row(16'hffff, PMAX, PMAX, 0, 0, PMIN, PMIN, 0, 0, 0, 0);
        add_row(16'hffff, 1000, -7000, VMAX, VMAX, 0, 0, 0, 0, 0, 0);
        add_row(0, 256, 0, 0, 0, 0, 0, 1, 1, 24'd0, 24'd0);
        add_row(0, 256, 0, 256, 0, 0, 0, 1, 0, 0, 0);
        // predicted point lands on the shooter
        add_row(0, 256, 0, -256, 0, 0, 0, 1, 1, 24'd0, 24'd0);
        // '+' root numerator is exactly zero
        add_row(3, 1, 0, 2, 2, 0, 0, 1, 0, 0, 0);
        add_row(3, 1, 0, -2, 2, 0, 0, 0, 0, 0, 0);
        add_row(1, PMIN, PMIN, VMAX, VMAX, PMIN, PMIN, 1, 1, 24'd1, 24'd0);
        add_row(1, 4096, -300, -3, 1, 17, 9, 0, 0, 0, 0);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 8;
        rx_idle_pct = 49;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].speed != speed_reg) write_speed(dir_rows[i].speed);
            send_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].shot);
        end

        for (int ph = 0; ph < 6; ph++) begin
            write_speed(phase_speed[ph]);
            tx_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 49 : 0;
            rx_idle_pct = (ph < 2) ? 49 : (ph < 4) ? 8 : 0;
            for (int k = 0; k < 330; k++) begin
                if (ph == 4 && k == 20) hold_req = 1'b1;
                send_query(random_query(), 1'b0, none);
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        $display("Ran %0d queries over 7 speed settings; %0d results checked, %0d solved.",
                 queries_sent, shots_checked, solved_seen);
        if (mismatch_count == 0 && expected_shots.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/icsu_pkg.sv
hw/rtl/icsu_isqrt.sv
hw/rtl/icsu_div2.sv
hw/rtl/intercept_course_solver_unit.sv
sim/intercept_course_solver_unit_tb.sv
